// ----- src/uscivil_pkg.sv -----
// types, constants and reciprocal divider constants for unix_seconds_to_civil_time
// depends on nothing; imported by the top level

package uscivil_pkg;

   localparam int STAMP_BITS = 36;
   localparam int NUM_STAGES = 14;

   localparam int ZONE_W = 5;
   localparam int ZONE_SECS_W = 17;
   localparam int SECS_W = STAMP_BITS + 1;
   localparam int SEC_LOW_W = 7;
   localparam int DAY_XW = SECS_W - SEC_LOW_W;
   localparam int DAYS_W = DAY_XW - 9;
   localparam int ZW = ((DAYS_W > 20) ? DAYS_W : 20) + 1;
   localparam int ERA_W = ZW - 17;
   localparam int YEAR_W = ZW - 7;
   localparam int Y7_W = DAYS_W + 1;
   localparam int REM_W = 17;
   localparam int MREM_W = 12;
   localparam int DOE_W = 18;
   localparam int YOE_W = 9;
   localparam int DOY_W = 9;
   localparam int MPX_W = 11;

   localparam longint unsigned SECS_PER_HOUR = 3600;
   localparam longint unsigned EPOCH_SHIFT_DAYS = 719468;
   localparam longint unsigned DAYS_PER_ERA = 146097;
   localparam longint unsigned YEARS_PER_ERA = 400;
   localparam longint unsigned EPOCH_YEAR = 1970;
   localparam longint unsigned LAST_DAY_OF_ERA = 146096;

   // seconds >> 7 divided by 675 gives whole days
   localparam longint unsigned DAY_DIV = 675;
   localparam int DAY_K = DAY_XW + 10;
   localparam longint unsigned DAY_M = ((64'd1 << DAY_K) + DAY_DIV - 1) / DAY_DIV;
   localparam int DAY_PW = DAY_K + DAYS_W;

   localparam int ERA_K = ZW + 18;
   localparam longint unsigned ERA_M = ((64'd1 << ERA_K) + DAYS_PER_ERA - 1) / DAYS_PER_ERA;
   localparam int ERA_PW = ERA_K + ERA_W;

   localparam longint unsigned WEEK_DIV = 7;
   localparam int WEEK_K = Y7_W + 3;
   localparam int WEEK_QW = DAYS_W - 1;
   localparam longint unsigned WEEK_M = ((64'd1 << WEEK_K) + WEEK_DIV - 1) / WEEK_DIV;
   localparam int WEEK_PW = WEEK_K + WEEK_QW;

   localparam int HOUR_K = REM_W + 12;
   localparam longint unsigned HOUR_M = ((64'd1 << HOUR_K) + SECS_PER_HOUR - 1) / SECS_PER_HOUR;
   localparam int HOUR_PW = HOUR_K + 5;

   localparam longint unsigned MIN_DIV = 60;
   localparam int MIN_K = MREM_W + 6;
   localparam longint unsigned MIN_M = ((64'd1 << MIN_K) + MIN_DIV - 1) / MIN_DIV;
   localparam int MIN_PW = MIN_K + 6;

   localparam longint unsigned C1460_DIV = 1460;
   localparam int C1460_K = DOE_W + 11;
   localparam int C1460_QW = 7;
   localparam longint unsigned C1460_M = ((64'd1 << C1460_K) + C1460_DIV - 1) / C1460_DIV;
   localparam int C1460_PW = C1460_K + C1460_QW;

   localparam longint unsigned C36524_DIV = 36524;
   localparam int C36524_K = DOE_W + 16;
   localparam int C36524_QW = 3;
   localparam longint unsigned C36524_M = ((64'd1 << C36524_K) + C36524_DIV - 1) / C36524_DIV;
   localparam int C36524_PW = C36524_K + C36524_QW;

   localparam longint unsigned Y365_DIV = 365;
   localparam int Y365_K = DOE_W + 9;
   localparam longint unsigned Y365_M = ((64'd1 << Y365_K) + Y365_DIV - 1) / Y365_DIV;
   localparam int Y365_PW = Y365_K + YOE_W;

   localparam longint unsigned C100_DIV = 100;
   localparam int C100_K = YOE_W + 7;
   localparam int C100_QW = 2;
   localparam longint unsigned C100_M = ((64'd1 << C100_K) + C100_DIV - 1) / C100_DIV;
   localparam int C100_PW = C100_K + C100_QW;

   localparam longint unsigned MP_DIV = 153;
   localparam int MP_K = MPX_W + 8;
   localparam longint unsigned MP_M = ((64'd1 << MP_K) + MP_DIV - 1) / MP_DIV;
   localparam int MP_PW = MP_K + 4;

   typedef struct packed {
      logic [STAMP_BITS-1:0] stamp;
      logic [SECS_W-1:0]     secs;
      logic [DAY_PW-1:0]     prod_day;
      logic [DAYS_W-1:0]     days;
      logic [REM_W-1:0]      rem;
      logic [ZW-1:0]         z;
      logic [Y7_W-1:0]       y7;
      logic [HOUR_PW-1:0]    prod_hr;
      logic [ERA_PW-1:0]     prod_era;
      logic [WEEK_PW-1:0]    prod_wd;
      logic [4:0]            hour;
      logic [MREM_W-1:0]     mrem;
      logic [ERA_W-1:0]      era;
      logic [DOE_W-1:0]      doe;
      logic [2:0]            weekday;
      logic [MIN_PW-1:0]     prod_min;
      logic [C1460_PW-1:0]   prod_1460;
      logic [C36524_PW-1:0]  prod_36524;
      logic                  last_day;
      logic [5:0]            minute;
      logic [5:0]            second;
      logic [DOE_W-1:0]      tnum;
      logic [Y365_PW-1:0]    prod_365;
      logic [YOE_W-1:0]      yoe;
      logic [C100_PW-1:0]    prod_100;
      logic [DOE_W-1:0]      yoe365;
      logic [DOY_W-1:0]      doy;
      logic [MP_PW-1:0]      prod_mp;
      logic [3:0]            month;
      logic [4:0]            day;
      logic [7:0]            yoff;
      logic                  yrange;
   } pipe_type;

   // first day of each month in a march-based year
   function automatic logic [DOY_W-1:0] month_start(input logic [3:0] mp);
      logic [DOY_W-1:0] start;
      case (mp)
         4'd0:    start = 9'd0;
         4'd1:    start = 9'd31;
         4'd2:    start = 9'd61;
         4'd3:    start = 9'd92;
         4'd4:    start = 9'd122;
         4'd5:    start = 9'd153;
         4'd6:    start = 9'd184;
         4'd7:    start = 9'd214;
         4'd8:    start = 9'd245;
         4'd9:    start = 9'd275;
         4'd10:   start = 9'd306;
         4'd11:   start = 9'd337;
         default: start = 9'd0;
      endcase
      return start;
   endfunction

endpackage

// ----- src/unix_seconds_to_civil_time.sv -----
// throughput: one timestamp per cycle unless stalled, set by a 14-stage pipeline of
// reciprocal multiplies; each stage holds while the one after it is full and stalled
// reset: synchronous, clears all stage valid bits and the zone offset to zero
// holds the complete converter: zone offset, day split, civil date, time, weekday
// depends on uscivil_pkg

module unix_seconds_to_civil_time (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic signed [uscivil_pkg::ZONE_W-1:0] csr_zone_offset_hours,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [uscivil_pkg::STAMP_BITS-1:0] req_utc_seconds,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [7:0]                         rsp_year_offset,
   output logic [3:0]                         rsp_month_number,
   output logic [4:0]                         rsp_day_of_month,
   output logic [4:0]                         rsp_hour_of_day,
   output logic [5:0]                         rsp_minute_of_hour,
   output logic [5:0]                         rsp_second_of_minute,
   output logic [2:0]                         rsp_weekday_number,
   output logic [uscivil_pkg::STAMP_BITS-1:0] rsp_stamp_echo,
   output logic                               rsp_year_out_of_range
);

   import uscivil_pkg::*;

   logic signed [ZONE_SECS_W-1:0] zone_secs_ff;
   logic signed [SECS_W:0]        local_sum;
   logic [NUM_STAGES:1]           vld_ff;
   logic [NUM_STAGES:1]           stage_en;
   pipe_type                      stg_ff [1:NUM_STAGES];
   pipe_type                      stg_in [1:NUM_STAGES];

   logic [DAY_XW-1:0] rem_hi;
   logic [REM_W-1:0]  mrem_sub;
   logic [ZW-1:0]     era_sub;
   logic [Y7_W-1:0]   wd_sub;
   logic [MREM_W-1:0] sec_sub;
   logic [DOE_W-1:0]  doy_sub;
   logic [YEAR_W-1:0] year_sum;
   logic [YEAR_W-1:0] year_off;
   logic [3:0]        mp;
   logic [3:0]        month_num;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_secs_ff <= '0;
      end else if (csr_valid) begin
         zone_secs_ff <= ZONE_SECS_W'(csr_zone_offset_hours)
                         * ZONE_SECS_W'(signed'(18'(SECS_PER_HOUR)));
      end
   end

   // stall chain, a stage takes new data when empty or when it moves on
   always_comb begin
      stage_en[NUM_STAGES] = !vld_ff[NUM_STAGES] || rsp_ready;
      for (int i = NUM_STAGES - 1; i >= 1; i--) begin
         stage_en[i] = !vld_ff[i] || stage_en[i+1];
      end
   end

   assign req_ready = stage_en[1];
   assign local_sum = $signed({2'b00, req_utc_seconds}) + (SECS_W+1)'(zone_secs_ff);

   always_comb begin
      // zone offset and clamp
      stg_in[1] = '0;
      stg_in[1].stamp = req_utc_seconds;
      stg_in[1].secs = local_sum[SECS_W] ? '0 : local_sum[SECS_W-1:0];

      // day reciprocal
      stg_in[2] = stg_ff[1];
      stg_in[2].prod_day = DAY_PW'(stg_ff[1].secs[SECS_W-1:SEC_LOW_W]) * DAY_PW'(DAY_M);

      // whole days and second of day
      stg_in[3] = stg_ff[2];
      stg_in[3].days = stg_ff[2].prod_day[DAY_K +: DAYS_W];
      rem_hi = stg_ff[2].secs[SECS_W-1:SEC_LOW_W]
               - DAY_XW'(stg_in[3].days) * DAY_XW'(DAY_DIV);
      stg_in[3].rem = {rem_hi[9:0], stg_ff[2].secs[SEC_LOW_W-1:0]};

      // shifted day count, weekday base, hour reciprocal
      stg_in[4] = stg_ff[3];
      stg_in[4].z = ZW'(stg_ff[3].days) + ZW'(EPOCH_SHIFT_DAYS);
      stg_in[4].y7 = Y7_W'(stg_ff[3].days) + Y7_W'(4);
      stg_in[4].prod_hr = HOUR_PW'(stg_ff[3].rem) * HOUR_PW'(HOUR_M);

      stg_in[5] = stg_ff[4];
      stg_in[5].prod_era = ERA_PW'(stg_ff[4].z) * ERA_PW'(ERA_M);
      stg_in[5].prod_wd = WEEK_PW'(stg_ff[4].y7) * WEEK_PW'(WEEK_M);
      stg_in[5].hour = stg_ff[4].prod_hr[HOUR_K +: 5];
      mrem_sub = stg_ff[4].rem - REM_W'(stg_in[5].hour) * REM_W'(SECS_PER_HOUR);
      stg_in[5].mrem = mrem_sub[MREM_W-1:0];

      // era, day of era, weekday, minute reciprocal
      stg_in[6] = stg_ff[5];
      stg_in[6].era = stg_ff[5].prod_era[ERA_K +: ERA_W];
      era_sub = stg_ff[5].z - ZW'(stg_in[6].era) * ZW'(DAYS_PER_ERA);
      stg_in[6].doe = era_sub[DOE_W-1:0];
      wd_sub = stg_ff[5].y7
               - Y7_W'(stg_ff[5].prod_wd[WEEK_K +: WEEK_QW]) * Y7_W'(WEEK_DIV);
      stg_in[6].weekday = (wd_sub[2:0] == 3'd0) ? 3'd7 : wd_sub[2:0];
      stg_in[6].prod_min = MIN_PW'(stg_ff[5].mrem) * MIN_PW'(MIN_M);

      // leap corrections, minute and second
      stg_in[7] = stg_ff[6];
      stg_in[7].prod_1460 = C1460_PW'(stg_ff[6].doe) * C1460_PW'(C1460_M);
      stg_in[7].prod_36524 = C36524_PW'(stg_ff[6].doe) * C36524_PW'(C36524_M);
      stg_in[7].last_day = (stg_ff[6].doe == DOE_W'(LAST_DAY_OF_ERA));
      stg_in[7].minute = stg_ff[6].prod_min[MIN_K +: 6];
      sec_sub = stg_ff[6].mrem - MREM_W'(stg_in[7].minute) * MREM_W'(MIN_DIV);
      stg_in[7].second = sec_sub[5:0];

      stg_in[8] = stg_ff[7];
      stg_in[8].tnum = stg_ff[7].doe
                       - DOE_W'(stg_ff[7].prod_1460[C1460_K +: C1460_QW])
                       + DOE_W'(stg_ff[7].prod_36524[C36524_K +: C36524_QW])
                       - DOE_W'(stg_ff[7].last_day);

      stg_in[9] = stg_ff[8];
      stg_in[9].prod_365 = Y365_PW'(stg_ff[8].tnum) * Y365_PW'(Y365_M);

      // year of era
      stg_in[10] = stg_ff[9];
      stg_in[10].yoe = stg_ff[9].prod_365[Y365_K +: YOE_W];

      stg_in[11] = stg_ff[10];
      stg_in[11].prod_100 = C100_PW'(stg_ff[10].yoe) * C100_PW'(C100_M);
      stg_in[11].yoe365 = DOE_W'(stg_ff[10].yoe) * DOE_W'(Y365_DIV);

      // day of march-based year
      stg_in[12] = stg_ff[11];
      doy_sub = stg_ff[11].doe
                - (stg_ff[11].yoe365 + DOE_W'(stg_ff[11].yoe[YOE_W-1:2])
                   - DOE_W'(stg_ff[11].prod_100[C100_K +: C100_QW]));
      stg_in[12].doy = doy_sub[DOY_W-1:0];

      stg_in[13] = stg_ff[12];
      stg_in[13].prod_mp = MP_PW'((MPX_W'(stg_ff[12].doy) << 2) + MPX_W'(stg_ff[12].doy)
                                  + MPX_W'(2)) * MP_PW'(MP_M);

      // month, day, year
      stg_in[14] = stg_ff[13];
      mp = stg_ff[13].prod_mp[MP_K +: 4];
      month_num = (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
      stg_in[14].month = month_num;
      stg_in[14].day = 5'(stg_ff[13].doy - month_start(mp) + 9'd1);
      year_sum = YEAR_W'(stg_ff[13].yoe)
                 + YEAR_W'(stg_ff[13].era) * YEAR_W'(YEARS_PER_ERA)
                 + YEAR_W'(month_num <= 4'd2);
      year_off = year_sum - YEAR_W'(EPOCH_YEAR);
      stg_in[14].yoff = year_off[7:0];
      stg_in[14].yrange = |year_off[YEAR_W-1:8];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (stage_en[1]) begin
            vld_ff[1] <= req_valid;
         end
         for (int i = 2; i <= NUM_STAGES; i++) begin
            if (stage_en[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 1; i <= NUM_STAGES; i++) begin
         if (stage_en[i]) begin
            stg_ff[i] <= stg_in[i];
         end
      end
   end

   assign rsp_valid             = vld_ff[NUM_STAGES];
   assign rsp_year_offset       = stg_ff[NUM_STAGES].yoff;
   assign rsp_month_number      = stg_ff[NUM_STAGES].month;
   assign rsp_day_of_month      = stg_ff[NUM_STAGES].day;
   assign rsp_hour_of_day       = stg_ff[NUM_STAGES].hour;
   assign rsp_minute_of_hour    = stg_ff[NUM_STAGES].minute;
   assign rsp_second_of_minute  = stg_ff[NUM_STAGES].second;
   assign rsp_weekday_number    = stg_ff[NUM_STAGES].weekday;
   assign rsp_stamp_echo        = stg_ff[NUM_STAGES].stamp;
   assign rsp_year_out_of_range = stg_ff[NUM_STAGES].yrange;

endmodule

// ----- tb/unix_seconds_to_civil_time_tb.sv -----
// self-checking testbench for unix_seconds_to_civil_time: predicts local civil time per
// timestamp transfer and checks every result transfer in order; depends on uscivil_pkg and the rtl

module unix_seconds_to_civil_time_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STAMP_W = uscivil_pkg::STAMP_BITS;
   localparam int ZONE_BITS = uscivil_pkg::ZONE_W;
   localparam longint SECONDS_PER_DAY = 86400;
   localparam longint SECONDS_PER_HOUR = 3600;
   localparam longint MARCH_EPOCH_DAYS = 719468;
   localparam longint ERA_DAYS = 146097;
   localparam longint STAMP_MAX = (64'd1 << STAMP_W) - 1;
   localparam longint FIRST_LATE_YEAR_STAMP = 64'd8078572800;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 24;
   localparam int HOLD_CYCLES = 80;
   localparam int RANDOM_PHASES = 8;
   localparam int ITEMS_PER_PHASE = 160;

   localparam logic [STAMP_W-1:0] EDGE_STAMPS [14] = '{
      36'd0, 36'd1, 36'd86399, 36'd86400, 36'd259200,
      36'd951782399, 36'd951782400, 36'd4107456000, 36'd4107542400,
      36'd13574563200, 36'd8078572799, 36'd8078572800,
      36'd68719476735, 36'hAAAAAAAAA
   };

   typedef struct packed {
      logic [7:0]         year_offset;
      logic [3:0]         month_number;
      logic [4:0]         day_of_month;
      logic [4:0]         hour_of_day;
      logic [5:0]         minute_of_hour;
      logic [5:0]         second_of_minute;
      logic [2:0]         weekday_number;
      logic [STAMP_W-1:0] stamp_echo;
      logic               year_out_of_range;
   } civil_time_type;

   logic clock;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic signed [ZONE_BITS-1:0] csr_zone_offset_hours = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [STAMP_W-1:0] req_utc_seconds = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [7:0] rsp_year_offset;
   logic [3:0] rsp_month_number;
   logic [4:0] rsp_day_of_month;
   logic [4:0] rsp_hour_of_day;
   logic [5:0] rsp_minute_of_hour;
   logic [5:0] rsp_second_of_minute;
   logic [2:0] rsp_weekday_number;
   logic [STAMP_W-1:0] rsp_stamp_echo;
   logic rsp_year_out_of_range;

   civil_time_type pending_civil [$];
   civil_time_type oldest_civil;
   logic signed [ZONE_BITS-1:0] zone_now = '0;
   int mismatch_count = 0;
   int cycle_count = 0;
   int burst_left = 0;
   bit pressure_on = 0;
   bit hold_request = 0;
   int hold_left = 0;
   int pattern_age = 0;
   logic [15:0] stall_mask = '1;
   bit field_bad;

   unix_seconds_to_civil_time dut (
      .clock                 (clock),
      .reset                 (reset),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_zone_offset_hours (csr_zone_offset_hours),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_utc_seconds       (req_utc_seconds),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_year_offset       (rsp_year_offset),
      .rsp_month_number      (rsp_month_number),
      .rsp_day_of_month      (rsp_day_of_month),
      .rsp_hour_of_day       (rsp_hour_of_day),
      .rsp_minute_of_hour    (rsp_minute_of_hour),
      .rsp_second_of_minute  (rsp_second_of_minute),
      .rsp_weekday_number    (rsp_weekday_number),
      .rsp_stamp_echo        (rsp_stamp_echo),
      .rsp_year_out_of_range (rsp_year_out_of_range)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("FAILURE");
      $finish;
   end

   function automatic civil_time_type civil_from_stamp(input logic [STAMP_W-1:0] stamp,
                                                       input logic signed [ZONE_BITS-1:0] zone);
      civil_time_type r;
      longint local_secs, day_count, sec_of_day, shifted, era, doe, yoe, doy, mp;
      longint month, year, yoff, wd;
      local_secs = longint'(stamp) + longint'(zone) * SECONDS_PER_HOUR;
      if (local_secs < 0) local_secs = 0;
      day_count = local_secs / SECONDS_PER_DAY;
      sec_of_day = local_secs % SECONDS_PER_DAY;
      // march-based year inside a 400-year era
      shifted = day_count + MARCH_EPOCH_DAYS;
      era = shifted / ERA_DAYS;
      doe = shifted - era * ERA_DAYS;
      yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp = (5 * doy + 2) / 153;
      month = (mp < 10) ? mp + 3 : mp - 9;
      year = yoe + era * 400 + ((month <= 2) ? 1 : 0);
      yoff = year - 1970;
      // epoch day was a thursday
      wd = (4 + day_count) % 7;
      if (wd == 0) wd = 7;
      r.year_offset = yoff[7:0];
      r.month_number = month[3:0];
      r.day_of_month = 5'(doy - (153 * mp + 2) / 5 + 1);
      r.hour_of_day = 5'(sec_of_day / SECONDS_PER_HOUR);
      r.minute_of_hour = 6'((sec_of_day % SECONDS_PER_HOUR) / 60);
      r.second_of_minute = 6'(sec_of_day % 60);
      r.weekday_number = wd[2:0];
      r.stamp_echo = stamp;
      r.year_out_of_range = (yoff > 255);
      return r;
   endfunction

   function automatic bit field_differs(input string field, input longint unsigned want,
                                        input longint unsigned got);
      if (want == got) return 1'b0;
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      return 1'b1;
   endfunction

   function automatic logic [STAMP_W-1:0] pick_stamp();
      longint s;
      int unsigned sel;
      sel = $urandom_range(0, 9);
      case (sel)
         5: s = $urandom_range(0, 200000);
         6: s = FIRST_LATE_YEAR_STAMP + longint'($urandom_range(0, 345600)) - 172800;
         7: s = longint'($urandom_range(0, 795000)) * SECONDS_PER_DAY
               + longint'($urandom_range(0, 100800)) - 50400;
         8: s = STAMP_MAX - longint'($urandom_range(0, 2000000));
         9: s = longint'($urandom_range(0, 795000)) * SECONDS_PER_DAY;
         default: s = {4'($urandom), 32'($urandom)};
      endcase
      if (s < 0) s = 0;
      if (s > STAMP_MAX) s = STAMP_MAX;
      return s[STAMP_W-1:0];
   endfunction

   // result transfers checked in order
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_civil.size() == 0) begin
            $display("%0t: unexpected result, expected none actual stamp %0d",
                     $time, rsp_stamp_echo);
            mismatch_count++;
         end else begin
            oldest_civil = pending_civil.pop_front();
            field_bad = 1'b0;
            field_bad |= field_differs("year_offset", oldest_civil.year_offset,
                                       rsp_year_offset);
            field_bad |= field_differs("month_number", oldest_civil.month_number,
                                       rsp_month_number);
            field_bad |= field_differs("day_of_month", oldest_civil.day_of_month,
                                       rsp_day_of_month);
            field_bad |= field_differs("hour_of_day", oldest_civil.hour_of_day,
                                       rsp_hour_of_day);
            field_bad |= field_differs("minute_of_hour", oldest_civil.minute_of_hour,
                                       rsp_minute_of_hour);
            field_bad |= field_differs("second_of_minute", oldest_civil.second_of_minute,
                                       rsp_second_of_minute);
            field_bad |= field_differs("weekday_number", oldest_civil.weekday_number,
                                       rsp_weekday_number);
            field_bad |= field_differs("stamp_echo", oldest_civil.stamp_echo,
                                       rsp_stamp_echo);
            field_bad |= field_differs("year_out_of_range", oldest_civil.year_out_of_range,
                                       rsp_year_out_of_range);
            if (field_bad) mismatch_count++;
         end
      end
   end

   // receiver stall pattern, with a long hold-off on request
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         if (pattern_age == 0) begin
            pattern_age = 64;
            stall_mask = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
         end
         pattern_age--;
         rsp_ready <= stall_mask[0];
         stall_mask = {stall_mask[0], stall_mask[15:1]};
      end
   end

   task automatic send_stamp(input logic [STAMP_W-1:0] stamp);
      int unsigned idle;
      idle = 0;
      if (!pressure_on) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         end
         burst_left--;
      end
      @(negedge clock);
      if (idle > 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_utc_seconds <= stamp;
      do @(posedge clock); while (!req_ready);
      pending_civil.push_back(civil_from_stamp(stamp, zone_now));
   endtask

   task automatic drain_pipeline();
      @(negedge clock) req_valid <= 1'b0;
      while (pending_civil.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_zone(input logic signed [ZONE_BITS-1:0] zone);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_zone_offset_hours <= zone;
      do @(posedge clock); while (!csr_ready);
      zone_now = zone;
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   // reset zone, leap rules, epoch, late years and the top of the stamp range
   task automatic test_edge_dates();
      foreach (EDGE_STAMPS[i]) send_stamp(EDGE_STAMPS[i]);
   endtask

   // extreme offsets: clamp below the epoch, day rollover, late-year boundary
   task automatic test_zone_extremes();
      drain_pipeline();
      set_zone(ZONE_BITS'(-16));
      send_stamp(36'd0);
      send_stamp(36'd57599);
      send_stamp(36'd57600);
      send_stamp(36'd57601);
      drain_pipeline();
      set_zone(ZONE_BITS'(15));
      send_stamp(36'd32399);
      send_stamp(36'd32400);
      send_stamp(STAMP_MAX[STAMP_W-1:0]);
      drain_pipeline();
      set_zone(ZONE_BITS'(-12));
      send_stamp(36'd43199);
      send_stamp(36'd43200);
      drain_pipeline();
      set_zone(ZONE_BITS'(14));
      send_stamp(36'd8078522399);
      send_stamp(36'd8078522400);
   endtask

   task automatic test_random_zones();
      logic signed [ZONE_BITS-1:0] zone;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: zone = ZONE_BITS'(-16);
            1: zone = ZONE_BITS'(15);
            2: zone = ZONE_BITS'(-12);
            3: zone = ZONE_BITS'(14);
            6: zone = ZONE_BITS'(0);
            default: zone = 5'($urandom_range(0, 31));
         endcase
         drain_pipeline();
         set_zone(zone);
         repeat (ITEMS_PER_PHASE) send_stamp(pick_stamp());
      end
   endtask

   // receiver holds off while the sender keeps offering
   task automatic test_output_backpressure();
      hold_request = 1'b1;
      pressure_on = 1'b1;
      repeat (60) send_stamp(pick_stamp());
      pressure_on = 1'b0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      test_edge_dates();
      test_zone_extremes();
      test_random_zones();
      test_output_backpressure();
      drain_pipeline();
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
